/* sv/brb_pkg.sv */
// Shared constants, codes and index helpers for the byte ring buffer.
`default_nettype none

package brb_pkg;

  // Storage geometry
  localparam int DEPTH     = 512;
  localparam int MAX_BURST = 64;
  localparam int AW        = $clog2(DEPTH);
  localparam int CAP_LIMIT = 512;
  localparam int CAP_HI    = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;
  localparam int CAP_LO    = 2;

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int DATA_W  = 8;
  localparam int COUNT_W = 7;
  localparam int LEVEL_W = 9;
  localparam int CAP_W   = 10;

  typedef logic [AW-1:0]      idx_t;
  typedef logic [CAP_W-1:0]   cap_t;
  typedef logic [LEVEL_W-1:0] level_t;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SKIP  = 2'd3;

  // Step an index by one, wrapping at the capacity.
  function automatic idx_t wrap_inc(input idx_t idx, input cap_t cap);
    cap_t nxt;
    begin
      nxt = cap_t'(idx) + cap_t'(1);
      wrap_inc = (nxt >= cap) ? '0 : idx_t'(nxt);
    end
  endfunction

endpackage

`default_nettype wire

/* sv/brb_in_if.sv */
// Request channel: operation, write byte and burst count.
`default_nettype none

interface brb_in_if import brb_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [DATA_W-1:0]  data_in;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output func, output data_in, output count, input ready);
  modport sink   (input valid, input func, input data_in, input count, output ready);
endinterface

`default_nettype wire

/* sv/brb_out_if.sv */
// Response channel: one beat per result.
`default_nettype none

interface brb_out_if import brb_pkg::*;;
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  data_out;
  logic               data_valid;
  logic               ok;
  logic [LEVEL_W-1:0] level;
  logic               last;

  modport source (output valid, output data_out, output data_valid, output ok,
                  output level, output last, input ready);
  modport sink   (input valid, input data_out, input data_valid, input ok,
                  input level, input last, output ready);
endinterface

`default_nettype wire

/* sv/brb_ram.sv */
// Simple dual-port RAM, registered read data held while read enable is low.
`default_nettype none

module brb_ram #(
  parameter int DW = 8,
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/byte_ring_buffer_core.sv */
// Byte ring buffer core: circular byte FIFO, one slot kept empty, burst reads.
`default_nettype none

// Byte FIFO over a 512 x 8 synchronous RAM; capacity register sets the slots
// in use (clamped to 2..512), holding capacity-1 bytes. Writing the capacity
// empties the buffer. Write, skip, refused requests and zero-count read/peek
// give one beat each and are accepted back to back while the sink is ready.
// A read or peek of n bytes gives n beats, one per cycle while the sink is
// ready; the first byte passes through the RAM read data register, and the
// request port reopens once the last byte is loaded. The output register holds
// a beat under backpressure; during a burst the RAM read data register holds
// the next byte. Read indices move to their final value at accept; level on
// each read beat falls by one, on peek beats it stays. No clearing pass: bytes
// are only ever read after being written.

module byte_ring_buffer_core import brb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  brb_in_if.sink           req,
  brb_out_if.source        rsp
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_BURST = 1'b1;

  // Architectural state
  cap_t cap_reg;
  idx_t wi;
  idx_t ri;

  // Burst control
  logic               state;
  idx_t               rd_ptr;
  logic [COUNT_W-1:0] left;
  level_t             lvl_q;
  logic               is_read;

  // Output register
  logic               o_valid;
  logic [DATA_W-1:0]  o_data;
  logic               o_dv;
  logic               o_ok;
  level_t             o_level;
  logic               o_last;

  // Combinational
  cap_t   cap_eff;
  idx_t   wi_inc;
  logic   full;
  cap_t   lvl_wide;
  level_t lvl_now;
  logic   cnt_bad;
  cap_t   ri_sum;
  idx_t   ri_adv;
  logic   accept;
  logic   out_free;
  logic   load;
  logic   burst_start;
  logic   skip_ok;
  logic   more;
  logic   s_ok;
  level_t s_level;

  logic              ram_we;
  logic              ram_re;
  idx_t              ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Effective capacity, saturated into the legal range
  always_comb begin
    if (cap_reg > cap_t'(CAP_HI)) begin
      cap_eff = cap_t'(CAP_HI);
    end else if (cap_reg < cap_t'(CAP_LO)) begin
      cap_eff = cap_t'(CAP_LO);
    end else begin
      cap_eff = cap_reg;
    end
  end

  always_comb begin
    wi_inc = wrap_inc(wi, cap_eff);
    full   = (wi_inc == ri);
    if (wi >= ri) begin
      lvl_wide = cap_t'(wi) - cap_t'(ri);
    end else begin
      lvl_wide = cap_t'(wi) + cap_eff - cap_t'(ri);
    end
    lvl_now = lvl_wide[LEVEL_W-1:0];
    cnt_bad = (req.count > COUNT_W'(MAX_BURST)) ||
              (LEVEL_W'(req.count) > lvl_now);
    // count never exceeds level < capacity, so one subtract wraps it
    ri_sum = cap_t'(ri) + cap_t'(req.count);
    if (ri_sum >= cap_eff) begin
      ri_adv = idx_t'(ri_sum - cap_eff);
    end else begin
      ri_adv = idx_t'(ri_sum);
    end
  end

  assign out_free  = !o_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign load      = (state == ST_BURST) && out_free;
  assign more      = (left != COUNT_W'(1));

  assign burst_start = ((req.func == FUNC_READ) || (req.func == FUNC_PEEK)) &&
                       !cnt_bad && (req.count != '0);
  assign skip_ok     = (req.func == FUNC_SKIP) && !cnt_bad;

  // Single-beat result
  always_comb begin
    case (req.func)
      FUNC_WRITE: begin
        s_ok    = !full;
        s_level = full ? lvl_now : lvl_now + LEVEL_W'(1);
      end
      FUNC_SKIP: begin
        s_ok    = !cnt_bad;
        s_level = cnt_bad ? lvl_now : lvl_now - LEVEL_W'(req.count);
      end
      default: begin
        // read or peek: refused, or count of zero
        s_ok    = !cnt_bad;
        s_level = lvl_now;
      end
    endcase
  end

  // Memory ports: a burst reads at the read index on accept, then one
  // address ahead each time a byte moves into the output register.
  assign ram_we    = accept && (req.func == FUNC_WRITE) && !full;
  assign ram_re    = (accept && burst_start) || (load && more);
  assign ram_raddr = accept ? ri : rd_ptr;

  brb_ram #(
    .DW (DATA_W),
    .AW (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wi),
    .wdata (req.data_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Capacity and indices
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= cap_t'(CAP_LIMIT);
      wi      <= '0;
      ri      <= '0;
    end else if (cfg_wr_en) begin
      cap_reg <= cfg_wr_data;
      wi      <= '0;
      ri      <= '0;
    end else if (accept) begin
      if (ram_we) begin
        wi <= wi_inc;
      end
      if (skip_ok || (burst_start && (req.func == FUNC_READ))) begin
        ri <= ri_adv;
      end
    end
  end

  // Burst sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (accept && burst_start) begin
      state <= ST_BURST;
    end else if (load && !more) begin
      state <= ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && burst_start) begin
      rd_ptr  <= wrap_inc(ri, cap_eff);
      left    <= req.count;
      lvl_q   <= lvl_now;
      is_read <= (req.func == FUNC_READ);
    end else if (load) begin
      if (more) begin
        rd_ptr <= wrap_inc(rd_ptr, cap_eff);
      end
      left <= left - COUNT_W'(1);
      if (is_read) begin
        lvl_q <= lvl_q - LEVEL_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (accept && !burst_start) begin
      o_valid <= 1'b1;
    end else if (load) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !burst_start) begin
      o_data  <= '0;
      o_dv    <= 1'b0;
      o_ok    <= s_ok;
      o_level <= s_level;
      o_last  <= 1'b1;
    end else if (load) begin
      o_data  <= ram_rdata;
      o_dv    <= 1'b1;
      o_ok    <= 1'b1;
      o_level <= is_read ? lvl_q - LEVEL_W'(1) : lvl_q;
      o_last  <= !more;
    end
  end

  assign rsp.valid      = o_valid;
  assign rsp.data_out   = o_data;
  assign rsp.data_valid = o_dv;
  assign rsp.ok         = o_ok;
  assign rsp.level      = o_level;
  assign rsp.last       = o_last;

endmodule

`default_nettype wire
